// ----- src/histogram_contrast_stretch_assert.svh -----
`ifndef HISTOGRAM_CONTRAST_STRETCH_ASSERT_SVH
`define HISTOGRAM_CONTRAST_STRETCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define HCS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hcs assertion failed");

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define HCS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hcs assertion failed");

`endif

// ----- src/hcs_pkg.sv -----
`default_nettype none

package hcs_pkg;

  localparam int HCS_MAX_COLS = 512;
  localparam int HCS_MAX_ROWS = 512;

  localparam int PIX_W = 8;
  localparam int DIM_W = 10;
  localparam int NUM_W = 2 * PIX_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;
  localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_ZERO  = 8'h00;

  // Configuration register indexes.
  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  // Item kinds.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE
  } hcs_state_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] numer;
    logic [PIX_W-1:0] denom;
  } hcs_div_req_t;

endpackage

`default_nettype wire

// ----- src/hcs_ram.sv -----
`default_nettype none

module hcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/hcs_divider.sv -----
`default_nettype none
`include "histogram_contrast_stretch_assert.svh"

module hcs_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire hcs_pkg::hcs_div_req_t      req,
  output logic                            done,
  output logic      [hcs_pkg::PIX_W-1:0]  quotient
);

  import hcs_pkg::*;

  localparam int CNT_W = $clog2(PIX_W);

  // The caller guarantees numer < denom * 2**PIX_W, so the quotient fits in
  // PIX_W bits and the upper half of numer starts as a partial remainder.
  logic             running;
  logic [CNT_W-1:0] count;
  logic [PIX_W-1:0] remainder;
  logic [PIX_W-1:0] shifter;
  logic [PIX_W-1:0] denom;
  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {remainder, shifter[PIX_W-1]};
    fits      = (trial >= {1'b0, denom});
    trial_sub = trial - {1'b0, denom};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == CNT_W'(PIX_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      remainder <= req.numer[NUM_W-1:PIX_W];
      shifter   <= req.numer[PIX_W-1:0];
      denom     <= req.denom;
    end else if (running) begin
      remainder <= fits ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
      shifter   <= {shifter[PIX_W-2:0], fits};
    end
  end

  assign quotient = shifter;

  `HCS_ASSERT_NEXT(a_div_done_after_run, running && count == CNT_W'(PIX_W - 1) && !req.go, done)
  `HCS_ASSERT_IMP(a_div_no_go_while_running, running, !req.go)
  `HCS_ASSERT_IMP(a_div_done_alone, done, !running)

endmodule

`default_nettype wire

// ----- src/histogram_contrast_stretch.sv -----
// Min-max contrast stretch of a grey frame held in an on-chip frame store.
// Input: an item is taken at a rising edge where start is high and busy is
// low; req_type selects a load (pixel_in is written to the store) or a read
// of the next stretched pixel. Loads leave busy low, so a load can be
// issued on every cycle. After num_cols * num_rows loads the block
// switches to readout; reads during loading and loads during readout are
// dropped without a result.
// Output: each read returns one beat, shown for exactly one cycle with done
// high, carrying pixel_out, last_of_frame, frame_min and frame_max. The
// receiver cannot stall it. Busy is high from the edge that accepts a read
// to the edge that raises done, while the read passes the frame-store read,
// the scaling step and the bit-serial divider, which retires one quotient
// bit per cycle, so a new read is taken only once the last one is through.
// Configuration: wr_en writes wr_data into register wr_index (0 num_cols,
// 1 num_rows); write only while the block is idle.
// Reset (rst, synchronous): back to loading, counters cleared, min 255,
// max 0. The frame store is not cleared; readout only visits entries that
// were written in the current frame.
`default_nettype none
`include "histogram_contrast_stretch_assert.svh"

module histogram_contrast_stretch #(
  parameter int MAX_COLS = hcs_pkg::HCS_MAX_COLS,
  parameter int MAX_ROWS = hcs_pkg::HCS_MAX_ROWS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type,
  input  wire logic [hcs_pkg::PIX_W-1:0]  pixel_in,
  output logic                            done,
  output logic      [hcs_pkg::PIX_W-1:0]  pixel_out,
  output logic                            last_of_frame,
  output logic      [hcs_pkg::PIX_W-1:0]  frame_min,
  output logic      [hcs_pkg::PIX_W-1:0]  frame_max,
  input  wire logic                       wr_en,
  input  wire logic                       wr_index,
  input  wire logic [hcs_pkg::DIM_W-1:0]  wr_data
);

  import hcs_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = $clog2(DEPTH + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);

  // Configuration registers.
  logic [DIM_W-1:0] num_cols;
  logic [DIM_W-1:0] num_rows;

  // Frame bookkeeping.
  hcs_state_t       state;
  hcs_state_t       state_next;
  logic             reading_phase;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] frame_total;
  logic [PIX_W-1:0] running_min;
  logic [PIX_W-1:0] running_max;

  logic             accept;
  logic             do_load;
  logic             do_read;
  logic             finish;

  logic [COL_W-1:0]       cols_c;
  logic [ROW_W-1:0]       rows_c;
  logic [COL_W+ROW_W-1:0] size_full;
  logic [POS_W-1:0]       frame_size;
  logic [POS_W-1:0]       pos_inc;
  logic                   load_ends;
  logic                   read_last;

  logic [PIX_W-1:0] store_q;
  logic [PIX_W-1:0] diff;
  logic [PIX_W-1:0] span;
  logic             flat;
  hcs_div_req_t     div_req;
  logic             div_done;
  logic [PIX_W-1:0] div_quot;

  assign accept  = start && !busy;
  assign do_load = accept && (req_type == REQ_LOAD) && !reading_phase;
  assign do_read = accept && (req_type == REQ_READ) && reading_phase;
  assign busy    = (state != ST_IDLE);
  assign finish  = (state == ST_DIVIDE) && div_done;

  // Frame size from the current registers; zero counts as one and values
  // above the store's dimensions are held at the maximum.
  always_comb begin
    if (num_cols == '0) begin
      cols_c = COL_W'(1);
    end else if (DIM_W'(num_cols) > MAX_COLS) begin
      cols_c = COL_W'(MAX_COLS);
    end else begin
      cols_c = COL_W'(num_cols);
    end
    if (num_rows == '0) begin
      rows_c = ROW_W'(1);
    end else if (DIM_W'(num_rows) > MAX_ROWS) begin
      rows_c = ROW_W'(MAX_ROWS);
    end else begin
      rows_c = ROW_W'(num_rows);
    end
  end

  assign size_full  = cols_c * rows_c;
  assign frame_size = size_full[POS_W-1:0];
  assign pos_inc    = position + 1'b1;
  // A size shrunk to no more than the loads so far plus one ends the frame on the next load.
  assign load_ends  = (pos_inc >= frame_size);
  assign read_last  = (pos_inc >= frame_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= DIM_RESET;
      num_rows <= DIM_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_NUM_COLS: num_cols <= wr_data;
        REG_NUM_ROWS: num_rows <= wr_data;
        default: ;
      endcase
    end
  end

  // Frame store: one write port for loads, one registered read for readout.
  hcs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_load),
    .waddr (position[ADDR_W-1:0]),
    .wdata (pixel_in),
    .re    (do_read),
    .raddr (position[ADDR_W-1:0]),
    .rdata (store_q)
  );

  // Scaling: (p - min) * 255, formed as a shift and a subtract, feeds the
  // divider together with the span max - min, which is fixed during readout.
  always_comb begin
    span = running_max - running_min;
    flat = (running_max <= running_min);
    diff = (store_q >= running_min) ? (store_q - running_min) : PIX_ZERO;
    div_req.go    = (state == ST_FETCH);
    div_req.numer = {diff, PIX_ZERO} - {PIX_ZERO, diff};
    div_req.denom = span;
  end

  hcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (do_read) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loads update the running extremes and the count; the readout beat
  // advances the count and, on the last pixel, rearms the next frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      reading_phase <= 1'b0;
      position      <= '0;
      frame_total   <= '0;
      running_min   <= PIX_MAX;
      running_max   <= PIX_ZERO;
    end else if (do_load) begin
      if (pixel_in < running_min) begin
        running_min <= pixel_in;
      end
      if (pixel_in > running_max) begin
        running_max <= pixel_in;
      end
      if (load_ends) begin
        frame_total   <= pos_inc;
        position      <= '0;
        reading_phase <= 1'b1;
      end else begin
        position <= pos_inc;
      end
    end else if (finish) begin
      if (read_last) begin
        position      <= '0;
        reading_phase <= 1'b0;
        running_min   <= PIX_MAX;
        running_max   <= PIX_ZERO;
        frame_total   <= '0;
      end else begin
        position <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pixel_out     <= flat ? PIX_ZERO : div_quot;
      last_of_frame <= read_last;
      frame_min     <= running_min;
      frame_max     <= running_max;
    end
  end

  `HCS_ASSERT_IMP(a_done_from_divide, done, $past(state) == ST_DIVIDE)
  `HCS_ASSERT_NEXT(a_read_starts_fetch, do_read, state == ST_FETCH)
  `HCS_ASSERT_IMP(a_loading_no_total, !reading_phase, frame_total == '0)
  `HCS_ASSERT_IMP(a_readout_in_frame, reading_phase, position < frame_total)
  `HCS_ASSERT_IMP(a_fresh_frame_extremes, !reading_phase && position == '0,
                  running_min == PIX_MAX && running_max == PIX_ZERO)

endmodule

`default_nettype wire

// ----- tb/stretch_checker.sv -----
module stretch_checker
  import hcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             req_type,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             done,
  input  logic [PIX_W-1:0] pixel_out,
  input  logic             last_of_frame,
  input  logic [PIX_W-1:0] frame_min,
  input  logic [PIX_W-1:0] frame_max,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [DIM_W-1:0] wr_data,
  output int unsigned      errors,
  output int unsigned      backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = HCS_MAX_COLS * HCS_MAX_ROWS;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             last;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
  } stretched_t;

  logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
  stretched_t       stretched_q [$];
  logic [DIM_W-1:0] cols_q = DIM_RESET;
  logic [DIM_W-1:0] rows_q = DIM_RESET;
  logic [PIX_W-1:0] run_min = PIX_MAX;
  logic [PIX_W-1:0] run_max = PIX_ZERO;
  int unsigned      pix_pos = 0;
  int unsigned      frame_len = 0;
  bit               reading = 1'b0;

  initial errors = 0;
  assign backlog = stretched_q.size();

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] stretch_level(logic [PIX_W-1:0] p,
                                                     logic [PIX_W-1:0] lo,
                                                     logic [PIX_W-1:0] hi);
    int unsigned span;
    int unsigned q;
    span = (hi > lo) ? int'(hi) - int'(lo) : 0;
    if (span == 0 || p < lo) return PIX_ZERO;
    q = ((int'(p) - int'(lo)) * 255) / span;
    if (q > 255) return PIX_MAX;
    return q[PIX_W-1:0];
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // One accepted beat through the frame model; a read in readout queues its result.
  task automatic stretch_predict(logic kind, logic [PIX_W-1:0] pix);
    stretched_t r;
    if (!reading) begin
      if (kind != REQ_LOAD) return;
      frame_copy[pix_pos] = pix;
      if (pix < run_min) run_min = pix;
      if (pix > run_max) run_max = pix;
      pix_pos++;
      if (pix_pos >= clamp_dim(cols_q, HCS_MAX_COLS) * clamp_dim(rows_q, HCS_MAX_ROWS)) begin
        frame_len = pix_pos;
        pix_pos   = 0;
        reading   = 1'b1;
      end
    end else if (kind == REQ_READ) begin
      r.level = stretch_level(frame_copy[pix_pos], run_min, run_max);
      r.last  = (pix_pos + 1 >= frame_len);
      r.lo    = run_min;
      r.hi    = run_max;
      stretched_q.push_back(r);
      if (r.last) begin
        reading   = 1'b0;
        pix_pos   = 0;
        frame_len = 0;
        run_min   = PIX_MAX;
        run_max   = PIX_ZERO;
      end else begin
        pix_pos++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    stretched_t want;
    if (rst) begin
      cols_q    = DIM_RESET;
      rows_q    = DIM_RESET;
      run_min   = PIX_MAX;
      run_max   = PIX_ZERO;
      pix_pos   = 0;
      frame_len = 0;
      reading   = 1'b0;
      stretched_q.delete();
    end else begin
      // A result always belongs to an older read, so it is matched first.
      if (done) begin
        if (stretched_q.size() == 0) begin
          $display("%0t: result with none expected, got pixel %0d last %0d min %0d max %0d",
                   $time, pixel_out, last_of_frame, frame_min, frame_max);
          errors++;
        end else begin
          want = stretched_q.pop_front();
          check_field("pixel_out", want.level, pixel_out);
          check_field("last_of_frame", want.last, last_of_frame);
          check_field("frame_min", want.lo, frame_min);
          check_field("frame_max", want.hi, frame_max);
        end
      end
      if (wr_en) begin
        if (wr_index == REG_NUM_COLS) cols_q = wr_data;
        else rows_q = wr_data;
      end
      if (start && !busy) stretch_predict(req_type, pixel_in);
    end
  end

endmodule

// ----- tb/tb_histogram_contrast_stretch.sv -----
module tb_histogram_contrast_stretch;
  timeunit 1ns;
  timeprecision 1ps;
  import hcs_pkg::*;

  // A read keeps the block busy until its result is raised, so this margin
  // covers any result still on its way.
  localparam int unsigned SETTLE_CYCLES = 16;

  // How the pixels of one frame are drawn.
  typedef enum int unsigned {
    SHADE_ANY,
    SHADE_BAND,
    SHADE_FLAT,
    SHADE_EDGES
  } shade_t;

  // Where, if anywhere, a size register is rewritten inside a frame.
  typedef enum int unsigned {
    TWIST_NONE,
    TWIST_LOAD,
    TWIST_READ
  } twist_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             req_type = REQ_LOAD;
  logic [PIX_W-1:0] pixel_in = PIX_ZERO;
  logic             done;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;
  logic [PIX_W-1:0] frame_min;
  logic [PIX_W-1:0] frame_max;
  logic             wr_en = 1'b0;
  logic             wr_index = REG_NUM_COLS;
  logic [DIM_W-1:0] wr_data = '0;

  int unsigned errors;
  int unsigned backlog;

  // Stimulus-side view of the size registers, so that each frame knows how
  // many loads and reads make it up.
  logic [DIM_W-1:0] cols_now = DIM_RESET;
  logic [DIM_W-1:0] rows_now = DIM_RESET;
  int unsigned      idle_pct = 0;
  int unsigned      band_lo = 0;
  int unsigned      band_w = 1;
  int unsigned      beats = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  histogram_contrast_stretch dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .pixel_in      (pixel_in),
    .done          (done),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .frame_min     (frame_min),
    .frame_max     (frame_max),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  stretch_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .pixel_in      (pixel_in),
    .done          (done),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .frame_min     (frame_min),
    .frame_max     (frame_max),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .errors        (errors),
    .backlog       (backlog)
  );

  // A zero size counts as one and anything above the maximum is clamped.
  function automatic int unsigned dim_eff(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return dim_eff(cols_now, HCS_MAX_COLS) * dim_eff(rows_now, HCS_MAX_ROWS);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(shade_t shade);
    case (shade)
      SHADE_ANY:  return PIX_W'($urandom_range(255));
      SHADE_BAND: return PIX_W'(band_lo + $urandom_range(band_w));
      SHADE_FLAT: return PIX_W'(band_lo);
      default:    return $urandom_range(1) ? PIX_MAX : PIX_ZERO;
    endcase
  endfunction

  // Offers one beat, after a random number of idle cycles, and returns at
  // the edge that takes it. Busy is sampled at the falling edge, where it is
  // settled, so acceptance never hangs on the order of events at the rising
  // edge. Start is left high; the next call either keeps it high with fresh
  // data or lowers it for a gap, in each case with one assignment per edge.
  task automatic send_beat(input logic kind, input logic [PIX_W-1:0] pix);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    pixel_in <= pix;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stops offering beats and waits until every expected result has been
  // seen, then lets a read that might still be under way run out. Loads
  // give no result, so the margin is needed even with nothing expected.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the trailing wait with the enable low keeps back-to-back
  // writes from raising and lowering the enable at the same edge.
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_NUM_COLS) cols_now = val;
    else rows_now = val;
    @(posedge clk);
  endtask

  // One whole frame: all its loads, then all its reads. Noisy frames sprinkle
  // in reads during loading and loads during readout, which the block must
  // drop. A twist rewrites one size register part-way through; during
  // loading that moves the end of the frame, during readout it must not.
  task automatic run_frame(input shade_t shade, input bit noisy, input twist_t twist);
    int unsigned total;
    int unsigned n_loaded;
    int unsigned i;
    logic [DIM_W-1:0] dim;
    total    = frame_pixels();
    band_w   = $urandom_range(1, 6);
    band_lo  = $urandom_range(255 - band_w);
    n_loaded = 0;
    while (n_loaded < total) begin
      if (noisy && $urandom_range(9) == 0) send_beat(REQ_READ, PIX_W'($urandom_range(255)));
      if (twist == TWIST_LOAD && n_loaded > 0 && n_loaded == total / 2) begin
        settle();
        dim = DIM_W'($urandom_range(7));
        if ($urandom_range(1)) write_reg(REG_NUM_COLS, dim);
        else write_reg(REG_NUM_ROWS, dim);
        // A size already reached by the loads so far ends the frame on the
        // next load.
        total = (n_loaded >= frame_pixels()) ? n_loaded + 1 : frame_pixels();
        twist = TWIST_NONE;
      end
      send_beat(REQ_LOAD, pick_pixel(shade));
      n_loaded++;
    end
    for (i = 0; i < total; i++) begin
      if (noisy && $urandom_range(9) == 0) send_beat(REQ_LOAD, PIX_W'($urandom_range(255)));
      if (twist == TWIST_READ && i == 1) begin
        settle();
        if ($urandom_range(1)) write_reg(REG_NUM_COLS, DIM_W'($urandom_range(1023)));
        else write_reg(REG_NUM_ROWS, DIM_W'($urandom_range(1023)));
      end
      send_beat(REQ_READ, PIX_W'($urandom_range(255)));
    end
    beats += 2 * total;
  endtask

  initial begin
    int unsigned phase;
    int unsigned goal;
    twist_t      twist;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frames. A two by two frame holding both extremes of the grey
    // scale, with a read offered before any load and a load offered during
    // readout, neither of which may give a result.
    idle_pct = 15;
    write_reg(REG_NUM_COLS, 2);
    write_reg(REG_NUM_ROWS, 2);
    send_beat(REQ_READ, 8'hAA);
    send_beat(REQ_LOAD, PIX_ZERO);
    send_beat(REQ_LOAD, PIX_MAX);
    send_beat(REQ_LOAD, 8'd128);
    send_beat(REQ_LOAD, 8'd1);
    send_beat(REQ_LOAD, 8'h55);
    repeat (4) send_beat(REQ_READ, PIX_ZERO);

    // A single-pixel frame, with a zero height that must count as one. Its
    // minimum equals its maximum, so the stretched value is zero.
    settle();
    write_reg(REG_NUM_COLS, 1);
    write_reg(REG_NUM_ROWS, 0);
    send_beat(REQ_LOAD, 8'd77);
    send_beat(REQ_READ, PIX_MAX);

    // The width shrinks below the pixels already loaded, so the next load
    // closes a frame of three.
    settle();
    write_reg(REG_NUM_COLS, 3);
    write_reg(REG_NUM_ROWS, 1);
    send_beat(REQ_LOAD, 8'd10);
    send_beat(REQ_LOAD, 8'd20);
    settle();
    write_reg(REG_NUM_COLS, 1);
    send_beat(REQ_LOAD, 8'd30);
    repeat (3) send_beat(REQ_READ, PIX_ZERO);

    // Sizes rewritten to out-of-range values during readout must leave the
    // length of the frame being read alone.
    settle();
    write_reg(REG_NUM_COLS, 2);
    send_beat(REQ_LOAD, 8'd5);
    send_beat(REQ_LOAD, 8'd6);
    send_beat(REQ_READ, PIX_ZERO);
    settle();
    write_reg(REG_NUM_COLS, 1023);
    write_reg(REG_NUM_ROWS, 1023);
    send_beat(REQ_READ, PIX_ZERO);

    // Random frames of small sizes, mostly clean, some noisy, a few with a
    // size change inside. The sender idles at a moderate rate first, then
    // heavily, then not at all.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 66 : 0;
      goal = beats + 280;
      while (beats < goal) begin
        settle();
        write_reg(REG_NUM_COLS, DIM_W'($urandom_range(7)));
        write_reg(REG_NUM_ROWS, DIM_W'($urandom_range(7)));
        if ($urandom_range(9) < 2) twist = $urandom_range(1) ? TWIST_LOAD : TWIST_READ;
        else twist = TWIST_NONE;
        run_frame(shade_t'($urandom_range(3)), $urandom_range(3) == 0, twist);
      end
    end

    settle();
    if (errors == 0 && backlog == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, several times the longest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
